[rtl/scc_pkg.sv]
// ----------------------------------------------------------------------------
// scc_pkg: shared types and codes of the segment cover counter
// Operation, status and state codes, plus the control word sent to each cell.
// ----------------------------------------------------------------------------
`default_nettype none

package scc_pkg;

  localparam int unsigned MaxSegments = 1024;
  localparam int unsigned CoordBits   = 32;

  localparam int unsigned OpW     = 2;
  localparam int unsigned FieldW  = 32;
  localparam int unsigned IndexW  = 16;
  localparam int unsigned CountW  = 11;
  localparam int unsigned StatusW = 2;

  typedef enum logic [OpW-1:0] {
    OP_LOAD  = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2,
    OP_CLR_X = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    STS_ANSWERED = 2'd0,
    STS_STORED   = 2'd1,
    STS_DROPPED  = 2'd2,
    STS_CLEARED  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } state_e;

  // per-cell control word
  typedef struct packed {
    logic wr;   // store the broadcast segment in this cell
    logic clr;  // drop this cell's segment
  } cell_ctrl_t;

endpackage

`default_nettype wire

[rtl/scc_cell.sv]
// ----------------------------------------------------------------------------
// scc_cell: one segment slot of the cover chain
// Holds one segment; adds its hit to the count word passing through.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_cell #(
  parameter int unsigned COORD_W = scc_pkg::CoordBits,
  parameter int unsigned CNT_W   = scc_pkg::CountW
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  scc_pkg::cell_ctrl_t      ctrl_i,
  input  wire signed [COORD_W-1:0] wr_start_i,
  input  wire signed [COORD_W-1:0] wr_end_i,
  input  wire signed [COORD_W-1:0] point_i,
  input  wire                      tok_i,
  input  wire        [CNT_W-1:0]   cnt_i,
  output logic                     tok_o,
  output logic       [CNT_W-1:0]   cnt_o
);

  logic                      valid_q;
  logic signed [COORD_W-1:0] start_q;
  logic signed [COORD_W-1:0] end_q;
  logic                      tok_q;
  logic        [CNT_W-1:0]   cnt_q;
  logic        [CNT_W-1:0]   cnt_d;
  logic                      hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= 1'b0;
    end else begin
      if (ctrl_i.clr) begin
        valid_q <= 1'b0;
      end else if (ctrl_i.wr) begin
        valid_q <= 1'b1;
      end
      tok_q <= tok_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr) begin
      start_q <= wr_start_i;
      end_q   <= wr_end_i;
    end
    cnt_q <= cnt_d;
  end

  // closed interval; reversed segments never hit
  assign hit   = valid_q && (start_q <= point_i) && (point_i <= end_q);
  assign cnt_d = cnt_i + CNT_W'(hit);

  assign tok_o = tok_q;
  assign cnt_o = cnt_q;

endmodule

`default_nettype wire

[rtl/segment_cover_counter.sv]
// ----------------------------------------------------------------------------
// segment_cover_counter: point-in-segment cover counter
// Table of closed segments in a row of cells; answers point cover queries.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis): tuser carries the op (load, query, clear; any op
//   with bit 1 set clears). tdata carries start/point, segment end and the
//   point tag. Output stream (m_axis): one word per input word, with the
//   cover count, the echoed tag (queries only) and a status in tuser.
//   Timing: one word is worked on at a time. A load or clear goes from IDLE
//   to HOLD, and its result enters the output register once that is free;
//   the next word is taken back in IDLE. A query walks a count token through
//   the MAX_SEGMENTS cells, one cell per cycle, then its count goes to HOLD
//   and into the output register; the next word is taken back in IDLE.
//   The output register decouples the sides: the next word is accepted
//   while a result still waits on a stalled m_axis; the following result
//   is then held until the output register frees up.
//   Reset: the segment table empties (all cell valid flags cleared, count
//   zero), both streams go idle. Segment storage itself is not cleared.
//   A load into a full table is dropped and reported with a status.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_cover_counter #(
  parameter int unsigned MAX_SEGMENTS = scc_pkg::MaxSegments,
  parameter int unsigned COORD_BITS   = scc_pkg::CoordBits
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // in: [31:0] coordinate, [63:32] segment_end, [79:64] point_index
  input  wire  [79:0] s_axis_tdata,
  // in: [1:0] op
  input  wire  [1:0]  s_axis_tuser,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // out: [10:0] cover_count, [26:11] result_index, [31:27] zero
  output logic [31:0] m_axis_tdata,
  // out: [1:0] status
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready
);

  localparam int unsigned TOT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned CNT_W = TOT_W;
  localparam int unsigned FW    = scc_pkg::FieldW;
  localparam int unsigned IW    = scc_pkg::IndexW;
  localparam int unsigned OW    = scc_pkg::CountW;

  // ---- input unpack ----
  logic [FW-1:0]  in_coord;
  logic [FW-1:0]  in_end;
  logic [IW-1:0]  in_index;
  scc_pkg::op_e   in_op;
  logic           in_acc;

  assign in_coord = s_axis_tdata[FW-1:0];
  assign in_end   = s_axis_tdata[2*FW-1:FW];
  assign in_index = s_axis_tdata[2*FW+IW-1:2*FW];
  assign in_op    = scc_pkg::op_e'(s_axis_tuser);
  assign in_acc   = s_axis_tvalid && s_axis_tready;

  // coordinates: low COORD_BITS of the field, or the field sign-extended
  logic signed [COORD_BITS-1:0] c_start;
  logic signed [COORD_BITS-1:0] c_end;

  if (COORD_BITS <= FW) begin : g_coord_narrow
    assign c_start = in_coord[COORD_BITS-1:0];
    assign c_end   = in_end[COORD_BITS-1:0];
  end else begin : g_coord_wide
    assign c_start = {{(COORD_BITS-FW){in_coord[FW-1]}}, in_coord};
    assign c_end   = {{(COORD_BITS-FW){in_end[FW-1]}}, in_end};
  end

  // ---- control state ----
  scc_pkg::state_e state_q, state_d;
  logic [TOT_W-1:0] total_q, total_d;
  logic             inj_q, inj_d;

  // pending result (waits here for the output register)
  logic [CNT_W-1:0]      pend_count_q, pend_count_d;
  logic [IW-1:0]         pend_index_q, pend_index_d;
  scc_pkg::status_e      pend_status_q, pend_status_d;
  logic signed [COORD_BITS-1:0] point_q, point_d;

  // output register
  logic                  out_vld_q, out_vld_d;
  logic [CNT_W-1:0]      out_count_q, out_count_d;
  logic [IW-1:0]         out_index_q, out_index_d;
  scc_pkg::status_e      out_status_q, out_status_d;

  logic ld_en;
  logic clr_en;

  // chain wiring
  logic             tok_w [MAX_SEGMENTS+1];
  logic [CNT_W-1:0] cnt_w [MAX_SEGMENTS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= scc_pkg::ST_IDLE;
      total_q   <= '0;
      inj_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      total_q   <= total_d;
      inj_q     <= inj_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_count_q  <= pend_count_d;
    pend_index_q  <= pend_index_d;
    pend_status_q <= pend_status_d;
    point_q       <= point_d;
    out_count_q   <= out_count_d;
    out_index_q   <= out_index_d;
    out_status_q  <= out_status_d;
  end

  always_comb begin
    state_d       = state_q;
    total_d       = total_q;
    inj_d         = 1'b0;
    pend_count_d  = pend_count_q;
    pend_index_d  = pend_index_q;
    pend_status_d = pend_status_q;
    point_d       = point_q;
    out_vld_d     = out_vld_q && !m_axis_tready;
    out_count_d   = out_count_q;
    out_index_d   = out_index_q;
    out_status_d  = out_status_q;
    ld_en         = 1'b0;
    clr_en        = 1'b0;
    s_axis_tready = 1'b0;

    unique case (state_q)
      scc_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          pend_count_d = '0;
          pend_index_d = '0;
          unique case (in_op)
            scc_pkg::OP_LOAD: begin
              if (total_q < TOT_W'(MAX_SEGMENTS)) begin
                ld_en         = 1'b1;
                total_d       = total_q + 1'b1;
                pend_status_d = scc_pkg::STS_STORED;
              end else begin
                pend_status_d = scc_pkg::STS_DROPPED;
              end
              state_d = scc_pkg::ST_HOLD;
            end
            scc_pkg::OP_QUERY: begin
              point_d       = c_start;
              pend_index_d  = in_index;
              pend_status_d = scc_pkg::STS_ANSWERED;
              inj_d         = 1'b1;
              state_d       = scc_pkg::ST_SCAN;
            end
            default: begin
              clr_en        = 1'b1;
              total_d       = '0;
              pend_status_d = scc_pkg::STS_CLEARED;
              state_d       = scc_pkg::ST_HOLD;
            end
          endcase
        end
      end
      scc_pkg::ST_SCAN: begin
        if (tok_w[MAX_SEGMENTS]) begin
          pend_count_d = cnt_w[MAX_SEGMENTS];
          state_d      = scc_pkg::ST_HOLD;
        end
      end
      scc_pkg::ST_HOLD: begin
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d    = 1'b1;
          out_count_d  = pend_count_q;
          out_index_d  = pend_index_q;
          out_status_d = pend_status_q;
          state_d      = scc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = scc_pkg::ST_IDLE;
      end
    endcase
  end

  // ---- row of segment cells ----
  assign tok_w[0] = inj_q;
  assign cnt_w[0] = '0;

  for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_cell
    scc_pkg::cell_ctrl_t ctrl;

    assign ctrl.wr  = ld_en && (total_q == TOT_W'(i));
    assign ctrl.clr = clr_en;

    scc_cell #(
      .COORD_W (COORD_BITS),
      .CNT_W   (CNT_W)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .wr_start_i (c_start),
      .wr_end_i   (c_end),
      .point_i    (point_q),
      .tok_i      (tok_w[i]),
      .cnt_i      (cnt_w[i]),
      .tok_o      (tok_w[i+1]),
      .cnt_o      (cnt_w[i+1])
    );
  end

  // ---- output pack ----
  logic [OW-1:0] out_count_f;

  if (CNT_W >= OW) begin : g_cnt_trunc
    assign out_count_f = out_count_q[OW-1:0];
  end else begin : g_cnt_ext
    assign out_count_f = {{(OW-CNT_W){1'b0}}, out_count_q};
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(32-OW-IW){1'b0}}, out_index_q, out_count_f};
  assign m_axis_tuser  = out_status_q;

  // ---- assertions ----
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= TOT_W'(MAX_SEGMENTS))
    else $error("segment total beyond table size");

  a_tok_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_w[MAX_SEGMENTS] |-> (state_q == scc_pkg::ST_SCAN))
    else $error("count token left the chain outside a scan");

  a_clear_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tuser[1]) |=> (total_q == '0))
    else $error("clear did not empty the table");

  a_load_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld_en |=> (total_q == $past(total_q) + 1'b1))
    else $error("stored segment not counted");

endmodule

`default_nettype wire

[verif/segment_cover_checker.sv]
// ----------------------------------------------------------------------------
// segment_cover_checker: result checker for the segment cover counter
// Watches both streams, keeps its own segment table, predicts one result
// word per accepted input word and compares them in order, field by field.
// ----------------------------------------------------------------------------
module segment_cover_checker
  import scc_pkg::*;
#(
  parameter int unsigned MAX_SEGMENTS = MaxSegments
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [79:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic [1:0]  m_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o,
  output int          dropped_o,
  output int          peak_cover_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CountW-1:0] cover_count;
    logic [IndexW-1:0] result_index;
    status_e           status;
  } cover_word_t;

  // stored segments; only slots below seg_total are ever read
  logic signed [FieldW-1:0] seg_lo [MAX_SEGMENTS];
  logic signed [FieldW-1:0] seg_hi [MAX_SEGMENTS];
  int unsigned seg_total;
  cover_word_t pending_covers[$];
  int fails, checked, dropped, peak_cover;

  // applies one input word to the table and returns the word it must cause
  function automatic cover_word_t apply_word(op_e op, logic signed [FieldW-1:0] coord,
                                             logic signed [FieldW-1:0] seg_end,
                                             logic [IndexW-1:0] idx);
    cover_word_t w;
    int unsigned hits;
    w    = '0;
    hits = 0;
    case (op)
      OP_LOAD: begin
        if (seg_total < MAX_SEGMENTS) begin
          seg_lo[seg_total] = coord;
          seg_hi[seg_total] = seg_end;
          seg_total++;
          w.status = STS_STORED;
        end else begin
          w.status = STS_DROPPED;
        end
      end
      OP_QUERY: begin
        // reversed segments fail one of the two bounds by themselves
        for (int i = 0; i < seg_total; i++)
          if (seg_lo[i] <= coord && coord <= seg_hi[i]) hits++;
        w.cover_count  = CountW'(hits);
        w.result_index = idx;
        w.status       = STS_ANSWERED;
      end
      default: begin
        seg_total = 0;
        w.status  = STS_CLEARED;
      end
    endcase
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cover_word_t want;
    if (!rst_ni) begin
      seg_total  = 0;
      pending_covers.delete();
      fails      = 0;
      checked    = 0;
      dropped    = 0;
      peak_cover = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        want = apply_word(op_e'(s_axis_tuser), s_axis_tdata[31:0], s_axis_tdata[63:32],
                          s_axis_tdata[79:64]);
        if (want.status == STS_DROPPED) dropped++;
        if (want.status == STS_ANSWERED && int'(want.cover_count) > peak_cover)
          peak_cover = int'(want.cover_count);
        pending_covers.push_back(want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        checked++;
        if (pending_covers.size() == 0) begin
          $error("result word with nothing pending: tdata %h tuser %h",
                 m_axis_tdata, m_axis_tuser);
          fails++;
        end else begin
          want = pending_covers.pop_front();
          if (m_axis_tdata[CountW-1:0] !== want.cover_count) begin
            $error("cover_count: expected %0d, got %0d", want.cover_count,
                   m_axis_tdata[CountW-1:0]);
            fails++;
          end
          if (m_axis_tdata[CountW+IndexW-1:CountW] !== want.result_index) begin
            $error("result_index: expected %h, got %h", want.result_index,
                   m_axis_tdata[CountW+IndexW-1:CountW]);
            fails++;
          end
          if (m_axis_tdata[31:CountW+IndexW] !== '0) begin
            $error("pad: expected 0, got %h", m_axis_tdata[31:CountW+IndexW]);
            fails++;
          end
          if (m_axis_tuser !== want.status) begin
            $error("status: expected %s, got %0d", want.status.name(), m_axis_tuser);
            fails++;
          end
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= pending_covers.size();
    checked_o    <= checked;
    dropped_o    <= dropped;
    peak_cover_o <= peak_cover;
  end

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the segment cover counter
// Drives loads, point queries and clears with random gaps and output stalls,
// including a filled table; the checker beside the block scores every word.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import scc_pkg::*;

  localparam int unsigned ItemTarget  = 1450;  // input words in the whole run
  localparam int unsigned FillAfter   = 200;   // fill the table once past this
  localparam int unsigned QuietTail   = 80;    // last words go without idling
  localparam int unsigned LongHold    = 300;   // long output stall, in cycles
  // a query walks the whole cell row, so that bounds the block's latency
  localparam int unsigned DrainCycles = MaxSegments + 16;
  localparam longint      RunLimitNs  = 64'd200_000_000;

  localparam logic [31:0] CoordMin = 32'h8000_0000;
  localparam logic [31:0] CoordMax = 32'h7FFF_FFFF;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic [79:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;

  // idle_on enables random gaps on both sides; long_stall asks the sink
  // for one long hold-off
  bit idle_on    = 1'b0;
  bit long_stall = 1'b0;

  int unsigned words_sent, loads_sent, queries_sent, clears_sent;
  int fail_count, pending, checked, dropped, peak_cover;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  segment_cover_counter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  segment_cover_checker cover_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked),
    .dropped_o     (dropped),
    .peak_cover_o  (peak_cover)
  );

  // Coordinate mix: mostly a narrow window around zero so that segments
  // overlap and queries hit, some full-range values, some range extremes.
  function automatic logic [31:0] pick_coord();
    int w;
    w = $urandom_range(0, 128);
    case ($urandom_range(0, 9))
      0, 1: return $urandom();
      2: begin
        case ($urandom_range(0, 5))
          0:       return CoordMin;
          1:       return CoordMax;
          2:       return CoordMin + 32'd1;
          3:       return CoordMax - 32'd1;
          4:       return 32'd0;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return 32'(w - 64);
    endcase
  endfunction

  // Offers one word and returns once it is taken. A gap, when drawn, comes
  // first, so valid is lowered right after the previous accept; without a
  // gap valid simply stays high into the next word.
  task automatic send_word(op_e op, logic [31:0] coord, logic [31:0] seg_end,
                           logic [15:0] idx);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {idx, seg_end, coord};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
    case (op)
      OP_LOAD:  loads_sent++;
      OP_QUERY: queries_sent++;
      default:  clears_sent++;
    endcase
  endtask

  // One episode: mostly a well-formed load-then-query run with random
  // content, sometimes preceded by a clear; one in ten is raw noise with
  // any op code (the spare op code included) and any field values.
  task automatic run_episode();
    int unsigned n_loads, n_queries, len;
    logic [31:0] lo;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6))
        send_word(op_e'($urandom_range(0, 3)), $urandom(), $urandom(), 16'($urandom()));
    end else begin
      if ($urandom_range(0, 2) == 0)
        send_word($urandom_range(0, 1) ? OP_CLEAR : OP_CLR_X, $urandom(), $urandom(),
                  16'($urandom()));
      n_loads   = $urandom_range(1, 24);
      n_queries = $urandom_range(1, 6);
      repeat (n_loads) begin
        lo  = pick_coord();
        len = $urandom_range(0, 40);
        // about one in eight segments is reversed and covers nothing
        if ($urandom_range(0, 7) == 0)
          send_word(OP_LOAD, lo, 32'(lo - len - 1), 16'($urandom()));
        else
          send_word(OP_LOAD, lo, 32'(lo + len), 16'($urandom()));
      end
      repeat (n_queries) send_word(OP_QUERY, pick_coord(), $urandom(), 16'($urandom()));
    end
  endtask

  // Clears, then loads past capacity: the last few loads must be dropped.
  // Every stored segment contains zero, so the query at zero reports a full
  // table and sets the top bit of the count.
  task automatic fill_table();
    send_word(OP_CLEAR, $urandom(), $urandom(), 16'($urandom()));
    repeat (MaxSegments + 4)
      send_word(OP_LOAD, 32'(-int'($urandom_range(0, 1 << 30))),
                32'($urandom_range(0, 1 << 30)), 16'($urandom()));
    send_word(OP_QUERY, 32'd0, $urandom(), 16'($urandom()));
    send_word(OP_QUERY, CoordMax, $urandom(), 16'($urandom()));
    send_word(OP_QUERY, pick_coord(), $urandom(), 16'($urandom()));
  endtask

  // Sink side: random short stalls while idling is on, and one long stall
  // on request, counted here so the sender keeps pushing meanwhile.
  initial begin : sink
    @(posedge rst_ni);
    @(posedge clk_i);
    m_axis_tready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (long_stall) begin
        long_stall = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int unsigned waited;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty table, whole-range and single-point segments,
    // a reversed segment, range extremes, both clear codes.
    send_word(OP_QUERY, 32'd0, CoordMax, 16'hFFFF);         // empty table
    send_word(OP_LOAD, CoordMin, CoordMax, 16'hFFFF);       // whole range
    send_word(OP_LOAD, 32'd0, 32'd0, 16'h0000);             // single point
    send_word(OP_LOAD, 32'd5, 32'hFFFF_FFFB, 16'h1234);     // reversed 5..-5
    send_word(OP_LOAD, CoordMax, CoordMax, 16'h0000);
    send_word(OP_LOAD, CoordMin, CoordMin, 16'hFFFF);
    send_word(OP_LOAD, 32'hFFFF_FFFF, 32'd1, 16'h8000);
    send_word(OP_QUERY, CoordMin, 32'd0, 16'h0000);
    send_word(OP_QUERY, CoordMax, CoordMin, 16'hFFFF);
    send_word(OP_QUERY, 32'd0, 32'hFFFF_FFFF, 16'h5AA5);
    send_word(OP_QUERY, 32'hFFFF_FFFF, 32'd0, 16'hA55A);
    send_word(OP_QUERY, 32'd5, 32'd0, 16'h0001);            // only whole range
    send_word(OP_QUERY, 32'd1, 32'd0, 16'h8000);
    send_word(OP_CLEAR, CoordMax, CoordMin, 16'hFFFF);
    send_word(OP_QUERY, 32'd0, 32'd0, 16'h7FFF);            // cleared table
    send_word(OP_LOAD, 32'hFFFF_FFF6, 32'd10, 16'h0000);
    send_word(OP_CLR_X, 32'd0, 32'd0, 16'h0000);            // spare code clears
    send_word(OP_QUERY, 32'd0, 32'd0, 16'h00FF);
    send_word(OP_LOAD, 32'd3, 32'd3, 16'hFFFF);
    send_word(OP_QUERY, 32'd3, CoordMax, 16'hFF00);

    // Back-pressure: the sink holds off for a long stretch while loads keep
    // coming, so the output register fills and the input stalls.
    idle_on    = 1'b0;
    long_stall = 1'b1;
    repeat (12) send_word(OP_LOAD, pick_coord(), pick_coord(), 16'($urandom()));

    while (words_sent < FillAfter) begin
      idle_on = ($urandom_range(0, 3) != 0);
      run_episode();
    end
    fill_table();
    while (words_sent < ItemTarget - QuietTail) begin
      idle_on = ($urandom_range(0, 3) != 0);
      run_episode();
    end
    idle_on = 1'b0;
    while (words_sent < ItemTarget) run_episode();
    s_axis_tvalid <= 1'b0;

    // let the checker see the last accept before trusting its pending count
    @(posedge clk_i);
    waited = 0;
    while (pending != 0 && waited < 4 * DrainCycles) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (pending != 0) $error("%0d expected result words never arrived", pending);

    $display("Sent %0d words (%0d loads, %0d queries, %0d clears), %0d results checked",
             words_sent, loads_sent, queries_sent, clears_sent, checked);
    $display("Table filled to capacity: %0d loads dropped, peak cover count %0d",
             dropped, peak_cover);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // hard stop far beyond the slowest expected run
  initial begin : watchdog
    #(RunLimitNs);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

[filelist.f]
rtl/scc_pkg.sv
rtl/scc_cell.sv
rtl/segment_cover_counter.sv
verif/segment_cover_checker.sv
verif/tb.sv
